>>> rtl/impd_pkg.sv
`default_nettype none

package impd_pkg;

  // sample and derived datapath widths
  localparam int SAMPLE_BITS = 13;
  localparam int ABS_W       = SAMPLE_BITS;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W       = SQ_W + 2;

  // fixed field widths
  localparam int PEAK_W     = 13;
  localparam int MAG_W      = 26;
  localparam int THR_W      = 26;
  localparam int HOLD_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS   = CFG_IDX_W'(1);

  // register reset values
  localparam logic [THR_W-1:0]  THRESH_RESET  = THR_W'(2366864);
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = HOLD_W'(200);

  // saturation limits of the result fields
  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};
  localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};

  // running state kept between samples
  typedef struct packed {
    logic [PEAK_W-1:0] peak_x;
    logic [PEAK_W-1:0] peak_y;
    logic [PEAK_W-1:0] peak_z;
    logic [TIME_W-1:0] last_ms;
  } impd_state_t;

  // one result word
  typedef struct packed {
    logic              impact;
    logic [MAG_W-1:0]  magnitude_sq;
    logic [PEAK_W-1:0] peak_x;
    logic [PEAK_W-1:0] peak_y;
    logic [PEAK_W-1:0] peak_z;
  } impd_result_t;

  // absolute value, most negative code maps to its unsigned magnitude
  function automatic logic [ABS_W-1:0] sample_abs(input logic [SAMPLE_BITS-1:0] s);
    logic [ABS_W-1:0] neg;
    neg = ABS_W'(~s) + ABS_W'(1);
    return s[SAMPLE_BITS-1] ? neg : ABS_W'(s);
  endfunction

  // clamp an absolute value to the peak field
  function automatic logic [PEAK_W-1:0] sat_peak(input logic [ABS_W-1:0] a);
    if (32'(a) > 32'(PEAK_MAX)) return PEAK_MAX;
    return PEAK_W'(a);
  endfunction

  // clamp the full sum of squares to the magnitude field
  function automatic logic [MAG_W-1:0] sat_mag(input logic [SUM_W-1:0] s);
    if (64'(s) > 64'(MAG_MAX)) return MAG_MAX;
    return MAG_W'(s);
  endfunction

endpackage

`default_nettype wire

>>> rtl/impd_in_if.sv
`default_nettype none

interface impd_in_if import impd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;
  logic [TIME_W-1:0]             now_ms;

  modport source (output valid, sample_x, sample_y, sample_z, now_ms, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, now_ms, output ready);
endinterface

`default_nettype wire

>>> rtl/impd_out_if.sv
`default_nettype none

interface impd_out_if import impd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              impact;
  logic [MAG_W-1:0]  magnitude_sq;
  logic [PEAK_W-1:0] peak_x;
  logic [PEAK_W-1:0] peak_y;
  logic [PEAK_W-1:0] peak_z;

  modport source (output valid, impact, magnitude_sq, peak_x, peak_y, peak_z, input ready);
  modport sink   (input valid, impact, magnitude_sq, peak_x, peak_y, peak_z, output ready);
endinterface

`default_nettype wire

>>> rtl/impd_cfg_if.sv
`default_nettype none

interface impd_cfg_if import impd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/impd_datapath.sv
`default_nettype none

module impd_datapath import impd_pkg::*; (
  input  wire logic [SAMPLE_BITS-1:0] sample_x,
  input  wire logic [SAMPLE_BITS-1:0] sample_y,
  input  wire logic [SAMPLE_BITS-1:0] sample_z,
  input  wire logic [TIME_W-1:0]      now_ms,
  input  wire logic [THR_W-1:0]       threshold_sq,
  input  wire logic [HOLD_W-1:0]      holdoff_ms,
  input  wire impd_state_t            state,
  output impd_state_t                 state_nxt,
  output impd_result_t                result
);

  logic [ABS_W-1:0]  ax, ay, az;
  logic [SQ_W-1:0]   ax_w, ay_w, az_w;
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  logic [SUM_W-1:0]  sum;
  logic [TIME_W-1:0] elapsed;
  logic [PEAK_W-1:0] sx, sy, sz;
  logic              hit;

  // per-axis magnitudes and squares
  always_comb begin
    ax   = sample_abs(sample_x);
    ay   = sample_abs(sample_y);
    az   = sample_abs(sample_z);
    ax_w = SQ_W'(ax);
    ay_w = SQ_W'(ay);
    az_w = SQ_W'(az);
    sqx  = ax_w * ax_w;
    sqy  = ay_w * ay_w;
    sqz  = az_w * az_w;
    sum  = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
  end

  // threshold and holdoff test, elapsed time wraps
  always_comb begin
    elapsed = now_ms - state.last_ms;
    hit     = (64'(sum) >= 64'(threshold_sq)) && (elapsed > TIME_W'(holdoff_ms));
  end

  // peak hold and next state
  always_comb begin
    sx = sat_peak(ax);
    sy = sat_peak(ay);
    sz = sat_peak(az);
    state_nxt.peak_x  = (sx > state.peak_x) ? sx : state.peak_x;
    state_nxt.peak_y  = (sy > state.peak_y) ? sy : state.peak_y;
    state_nxt.peak_z  = (sz > state.peak_z) ? sz : state.peak_z;
    state_nxt.last_ms = hit ? now_ms : state.last_ms;
  end

  // result word
  always_comb begin
    result.impact       = hit;
    result.magnitude_sq = sat_mag(sum);
    result.peak_x       = state_nxt.peak_x;
    result.peak_y       = state_nxt.peak_y;
    result.peak_z       = state_nxt.peak_z;
  end

endmodule

`default_nettype wire

>>> rtl/impact_detector_peak_hold.sv
`default_nettype none

// channel   modport  payload
// in_if     sink     sample_x, sample_y, sample_z (signed), now_ms
// out_if    source   impact, magnitude_sq, peak_x, peak_y, peak_z
// cfg_if    sink     index (0 threshold_sq, 1 holdoff_ms), data
//
// input register then result register: one word per cycle sustained while out_if.ready stays high
// the squares, sum and compares sit between the two register stages
// rst_n sync, active low: clears valid bits, peaks, last impact time; registers to defaults
// a stalled result holds the result register; the input register still takes
// a word while it is empty, so both stages fill before in_if.ready drops
// cfg_if is always ready; writes to unknown indexes are dropped

module impact_detector_peak_hold import impd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  impd_in_if.sink   in_if,
  impd_out_if.source out_if,
  impd_cfg_if.sink  cfg_if
);

  // input stage
  logic                   s1_v_r;
  logic [SAMPLE_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [TIME_W-1:0]      s1_now_r;

  // result stage and state
  logic                   out_v_r;
  impd_result_t           out_res_r;
  impd_state_t            state_r;
  impd_state_t            state_nxt;
  impd_result_t           res;

  // configuration registers
  logic [THR_W-1:0]       thr_r;
  logic [HOLD_W-1:0]      hold_r;

  logic                   s1_adv;
  logic                   in_take;

  // handshake
  assign s1_adv      = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || s1_adv;
  assign in_take     = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  impd_datapath u_datapath (
    .sample_x     (s1_x_r),
    .sample_y     (s1_y_r),
    .sample_z     (s1_z_r),
    .now_ms       (s1_now_r),
    .threshold_sq (thr_r),
    .holdoff_ms   (hold_r),
    .state        (state_r),
    .state_nxt    (state_nxt),
    .result       (res)
  );

  // valid bits and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_if.ready) begin
        s1_v_r <= in_if.valid;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
        if (s1_v_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r   <= in_if.sample_x;
      s1_y_r   <= in_if.sample_y;
      s1_z_r   <= in_if.sample_z;
      s1_now_r <= in_if.now_ms;
    end
    if (s1_adv && s1_v_r) begin
      out_res_r <= res;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESH_RESET;
      hold_r <= HOLDOFF_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_THRESHOLD_SQ: thr_r  <= THR_W'(cfg_if.data);
        REG_HOLDOFF_MS:   hold_r <= HOLD_W'(cfg_if.data);
        default: ;
      endcase
    end
  end

  // result channel
  assign out_if.valid        = out_v_r;
  assign out_if.impact       = out_res_r.impact;
  assign out_if.magnitude_sq = out_res_r.magnitude_sq;
  assign out_if.peak_x       = out_res_r.peak_x;
  assign out_if.peak_y       = out_res_r.peak_y;
  assign out_if.peak_z       = out_res_r.peak_z;

`ifndef ASSERT_OFF
  // a reported impact always meets the threshold
  a_impact_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.impact |-> 64'(out_res_r.magnitude_sq) >= 64'(thr_r))
    else $error("impact reported below threshold");

  // peaks never fall outside reset
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (state_r.peak_x >= $past(state_r.peak_x)) &&
                     (state_r.peak_y >= $past(state_r.peak_y)) &&
                     (state_r.peak_z >= $past(state_r.peak_z)))
    else $error("peak decreased");

  // an impact records the sample time
  a_last_time: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_adv && res.impact |=> state_r.last_ms == $past(s1_now_r))
    else $error("last impact time not updated");

  // a held input word is not dropped while the result stage stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_now_r))
    else $error("input stage lost a word under stall");
`endif

endmodule

`default_nettype wire

>>> sim/tb_impact_detector_peak_hold.sv
`timescale 1ns / 1ps

module tb_impact_detector_peak_hold import impd_pkg::*; ();

  localparam int PIPE_LAT        = 2;
  localparam int STALL_LIMIT     = 20000;
  localparam int LONG_HOLD       = 300;
  localparam int N_PHASES        = 9;
  localparam int ITEMS_PER_PHASE = 148;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    int                    sx;
    int                    sy;
    int                    sz;
    logic [TIME_W-1:0]     now;
    bit                    fixed;
    impd_result_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  impd_in_if  in_ch ();
  impd_out_if out_ch ();
  impd_cfg_if cfg_ch ();

  impact_detector_peak_hold dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #4 clk = ~clk;

  // shadow of the detector state and its registers
  logic [THR_W-1:0]  thr_sq      = THRESH_RESET;
  logic [HOLD_W-1:0] hold_ms     = HOLDOFF_RESET;
  logic [PEAK_W-1:0] held_x      = '0;
  logic [PEAK_W-1:0] held_y      = '0;
  logic [PEAK_W-1:0] held_z      = '0;
  logic [TIME_W-1:0] last_hit_ms = '0;

  impd_result_t due_results [$];
  stim_row_t    dir_rows [$];
  impd_result_t chk_want;
  impd_result_t chk_got;

  int mismatches  = 0;
  int n_samples   = 0;
  int n_impacts   = 0;
  int n_writes    = 0;
  int idle_cycles = 0;
  bit hold_out_req = 1'b0;

  function automatic int unsigned axis_abs(logic signed [SAMPLE_BITS-1:0] s);
    int v;
    v = s;
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [PEAK_W-1:0] raise_peak(logic [PEAK_W-1:0] pk, int unsigned a);
    int unsigned c;
    c = (a > PEAK_MAX) ? PEAK_MAX : a;
    return (c > pk) ? PEAK_W'(c) : pk;
  endfunction

  // update peaks and last impact time, return the word the detector owes
  function automatic impd_result_t track_sample(logic signed [SAMPLE_BITS-1:0] sx,
                                                logic signed [SAMPLE_BITS-1:0] sy,
                                                logic signed [SAMPLE_BITS-1:0] sz,
                                                logic [TIME_W-1:0] now);
    impd_result_t      r;
    int unsigned       mx;
    int unsigned       my;
    int unsigned       mz;
    longint unsigned   energy;
    logic [TIME_W-1:0] since;
    mx = axis_abs(sx);
    my = axis_abs(sy);
    mz = axis_abs(sz);
    energy = longint'(mx) * mx + longint'(my) * my + longint'(mz) * mz;
    since = now - last_hit_ms;
    held_x = raise_peak(held_x, mx);
    held_y = raise_peak(held_y, my);
    held_z = raise_peak(held_z, mz);
    r.impact = (energy >= thr_sq) && (since > hold_ms);
    if (r.impact) last_hit_ms = now;
    r.magnitude_sq = (energy > MAG_MAX) ? MAG_MAX : MAG_W'(energy);
    r.peak_x = held_x;
    r.peak_y = held_y;
    r.peak_z = held_z;
    return r;
  endfunction

  // axis value close to a target level, random sign
  function automatic logic signed [SAMPLE_BITS-1:0] near_level(int level);
    int v;
    v = level + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if ($urandom_range(0, 1) == 1) begin
      if (v > 4096) v = 4096;
      v = -v;
    end else if (v > 4095) begin
      v = 4095;
    end
    return SAMPLE_BITS'(v);
  endfunction

  function automatic stim_row_t samp_row(int sx, int sy, int sz, logic [TIME_W-1:0] now);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.sx = sx;
    r.sy = sy;
    r.sz = sz;
    r.now = now;
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // row whose word is known up front; the same peak on all axes
  function automatic stim_row_t fixed_row(int sx, int sy, int sz, logic [TIME_W-1:0] now,
                                          logic imp, logic [MAG_W-1:0] mag,
                                          logic [PEAK_W-1:0] pk);
    stim_row_t r;
    r = samp_row(sx, sy, sz, now);
    r.fixed = 1'b1;
    r.want.impact = imp;
    r.want.magnitude_sq = mag;
    r.want.peak_x = pk;
    r.want.peak_y = pk;
    r.want.peak_z = pk;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = samp_row(0, 0, 0, '0);
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  task automatic flag_error(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // offer one word and hold it until taken
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sx,
                             logic signed [SAMPLE_BITS-1:0] sy,
                             logic signed [SAMPLE_BITS-1:0] sz,
                             logic [TIME_W-1:0] now, bit fixed, impd_result_t want);
    impd_result_t guess;
    in_ch.valid    <= 1'b1;
    in_ch.sample_x <= sx;
    in_ch.sample_y <= sy;
    in_ch.sample_z <= sz;
    in_ch.now_ms   <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    guess = track_sample(sx, sy, sz, now);
    due_results.push_back(fixed ? want : guess);
    n_samples++;
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_THRESHOLD_SQ: thr_sq = data[THR_W-1:0];
      REG_HOLDOFF_MS:   hold_ms = data[HOLD_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  // compare each result word with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      chk_got.impact       = out_ch.impact;
      chk_got.magnitude_sq = out_ch.magnitude_sq;
      chk_got.peak_x       = out_ch.peak_x;
      chk_got.peak_y       = out_ch.peak_y;
      chk_got.peak_z       = out_ch.peak_z;
      if (chk_got.impact === 1'b1) n_impacts++;
      if (due_results.size() == 0) begin
        flag_error("result word with nothing owed");
      end else begin
        chk_want = due_results.pop_front();
        if (chk_got.impact !== chk_want.impact ||
            chk_got.magnitude_sq !== chk_want.magnitude_sq ||
            chk_got.peak_x !== chk_want.peak_x ||
            chk_got.peak_y !== chk_want.peak_y ||
            chk_got.peak_z !== chk_want.peak_z) begin
          flag_error($sformatf(
            "want imp %0d mag %0d pk %0d/%0d/%0d, got imp %0d mag %0d pk %0d/%0d/%0d",
            chk_want.impact, chk_want.magnitude_sq, chk_want.peak_x, chk_want.peak_y,
            chk_want.peak_z, chk_got.impact, chk_got.magnitude_sq, chk_got.peak_x,
            chk_got.peak_y, chk_got.peak_z));
        end
      end
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // result side back-pressure: segments of differing stall patterns
  initial begin : receiver
    int rx_mode;
    int rx_len;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        rx_mode = $urandom_range(0, 3);
        rx_len  = $urandom_range(4, 64);
        for (int c = 0; c < rx_len; c++) begin
          @(posedge clk);
          case (rx_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= (c % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_BITS-1:0] ax [3];
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] stamp;
    logic [THR_W-1:0]  set_thr;
    logic [HOLD_W-1:0] set_hold;
    int burst_left;
    int gap;
    int level;
    int lanes;
    int pick;
    bit steady;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.sample_x <= '0;
    in_ch.sample_y <= '0;
    in_ch.sample_z <= '0;
    in_ch.now_ms   <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings: small peaks first, then extremes
    dir_rows.push_back(fixed_row(0, 0, 0, 32'd0, 1'b0, '0, '0));
    dir_rows.push_back(samp_row(3, -5, 7, 32'd50));
    dir_rows.push_back(samp_row(2, -9, 1, 32'd60));
    dir_rows.push_back(samp_row(1538, 0, 0, 32'd150));
    // above threshold but too early after reset
    dir_rows.push_back(samp_row(1539, 0, 0, 32'd100));
    dir_rows.push_back(samp_row(1539, 0, 0, 32'd201));
    dir_rows.push_back(fixed_row(-4096, -4096, -4096, 32'd300, 1'b0, 26'd50331648, 13'd4096));
    dir_rows.push_back(fixed_row(4095, 4095, 4095, 32'd401, 1'b0, 26'd50307075, 13'd4096));
    dir_rows.push_back(fixed_row(4095, 4095, 4095, 32'd402, 1'b1, 26'd50307075, 13'd4096));
    // timestamp going backwards, then across the wrap
    dir_rows.push_back(samp_row(4095, -4096, 0, 32'd10));
    dir_rows.push_back(samp_row(0, 0, -4096, 32'hFFFF_FFFF));
    dir_rows.push_back(samp_row(0, 4000, 0, 32'd200));
    // unused indexes must not disturb the registers
    dir_rows.push_back(reg_row(REG_SPARE_2, 26'h3FF_FFFF));
    dir_rows.push_back(reg_row(REG_SPARE_3, 26'h2AA_AAAA));
    dir_rows.push_back(samp_row(1539, 0, 0, 32'h1000_0000));
    // threshold met exactly, zero holdoff
    dir_rows.push_back(reg_row(REG_THRESHOLD_SQ, 26'd1000000));
    dir_rows.push_back(reg_row(REG_HOLDOFF_MS, 26'd0));
    dir_rows.push_back(samp_row(1000, 0, 0, 32'h1000_0001));
    dir_rows.push_back(samp_row(1000, 0, 0, 32'h1000_0001));
    dir_rows.push_back(samp_row(999, 44, 0, 32'h1000_0002));
    // zero threshold with the longest holdoff
    dir_rows.push_back(reg_row(REG_THRESHOLD_SQ, 26'd0));
    dir_rows.push_back(reg_row(REG_HOLDOFF_MS, 26'd65535));
    dir_rows.push_back(samp_row(0, 0, 0, 32'h1001_0001));
    dir_rows.push_back(samp_row(0, 0, 0, 32'h1002_0000));
    // threshold at the top of its range, then at the largest sum
    dir_rows.push_back(reg_row(REG_THRESHOLD_SQ, 26'h3FF_FFFF));
    dir_rows.push_back(reg_row(REG_HOLDOFF_MS, 26'd0));
    dir_rows.push_back(fixed_row(-4096, -4096, -4096, 32'h2000_0000, 1'b0, 26'd50331648,
                                 13'd4096));
    dir_rows.push_back(reg_row(REG_THRESHOLD_SQ, 26'd50331648));
    dir_rows.push_back(reg_row(REG_HOLDOFF_MS, 26'h3FF_00C8));
    dir_rows.push_back(fixed_row(-4096, -4096, -4096, 32'h3000_0000, 1'b1, 26'd50331648,
                                 13'd4096));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else begin
        send_sample(SAMPLE_BITS'(dir_rows[i].sx), SAMPLE_BITS'(dir_rows[i].sy),
                    SAMPLE_BITS'(dir_rows[i].sz), dir_rows[i].now, dir_rows[i].fixed,
                    dir_rows[i].want);
      end
    end

    // random phases, each under its own register setting
    clock_ms = 32'h4000_0000;
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin set_thr = THRESH_RESET; set_hold = HOLDOFF_RESET; end
        1: begin set_thr = '0; set_hold = '0; end
        2: begin set_thr = '1; set_hold = '1; end
        3: begin set_thr = 26'd50331648; set_hold = 16'd1; end
        5: begin set_thr = 26'd1000000; set_hold = '1; end
        7: begin set_thr = 26'd100; set_hold = 16'd30; end
        default: begin
          set_thr  = THR_W'($urandom_range(0, 50331648));
          set_hold = HOLD_W'($urandom_range(0, 1000));
        end
      endcase
      write_reg(REG_THRESHOLD_SQ, CFG_DATA_W'(set_thr));
      write_reg(REG_HOLDOFF_MS, {10'($urandom), set_hold});
      if (p == 6) write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
      if (p == 4) clock_ms = 32'hFFFF_F000;
      if (p == 2) hold_out_req = 1'b1;
      steady = (p == 1);
      burst_left = $urandom_range(1, 24);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // bursts separated by short gaps
        if (burst_left == 0) begin
          gap = steady ? 0 : $urandom_range(0, 6);
          if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;

        // axes: near the threshold, full-range noise, or small
        pick  = $urandom_range(0, 9);
        lanes = $urandom_range(1, 3);
        level = int'($sqrt(real'(thr_sq) / lanes));
        for (int a = 0; a < 3; a++) begin
          if (pick < 4)
            ax[a] = (a < lanes) ? near_level(level)
                                : SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
          else if (pick < 7)
            ax[a] = SAMPLE_BITS'($urandom);
          else
            ax[a] = SAMPLE_BITS'(int'($urandom_range(0, 128)) - 64);
        end

        // timestamps mostly march forward around the holdoff window
        case ($urandom_range(0, 19))
          0:       stamp = $urandom;
          1:       stamp = clock_ms - $urandom_range(1, 5000);
          default: stamp = clock_ms + $urandom_range(0, 2 * int'(hold_ms) + 3);
        endcase
        clock_ms = stamp;

        send_sample(ax[0], ax[1], ax[2], stamp, 1'b0, '0);
      end
    end

    drain();
    $display("checked %0d samples (%0d flagged as impacts) with %0d register writes",
             n_samples, n_impacts, n_writes);
    $display("covered full-scale axes, threshold and holdoff edges, time wrap and stalls");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
